FILE: design/scpf_pkg.sv
// Shared types and constants for the sum-checksum packet framer.
// Used by every module of the framer; depends on nothing.
package scpf_pkg;

  localparam int unsigned MAX_PAYLOAD_INT = 1012;
  localparam logic [9:0]  MAX_PAYLOAD     = 10'(MAX_PAYLOAD_INT);
  localparam logic [7:0]  SYNC_BYTE_0     = 8'h44;
  localparam logic [7:0]  SYNC_BYTE_1     = 8'h4B;
  localparam logic [10:0] FRAME_OVERHEAD  = 11'd11;

  // Command queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Back-end sequencer steps: 0..9 are the header bytes
  localparam logic [3:0] STEP_HDR_LAST = 4'd9;
  localparam logic [3:0] STEP_PAY      = 4'd10;
  localparam logic [3:0] STEP_CHK      = 4'd11;
  localparam logic [3:0] STEP_ERR      = 4'd12;

  typedef struct packed {
    logic [7:0]  dest_address;
    logic [7:0]  message_number;
    logic [15:0] packet_type;
    logic [9:0]  payload_length;
    logic [7:0]  payload_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_of_frame;
    logic       length_error;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_HDR = 2'd0,
    CMD_PAY = 2'd1,
    CMD_ERR = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  dest;
    logic [7:0]  msg;
    logic [15:0] ptype;
    logic [9:0]  len;
    logic [7:0]  pbyte;
    logic        last;   // payload transaction closes the frame
  } cmd_t;

  typedef struct packed {
    logic head_valid;
    logic full;
  } q_status_t;

endpackage

FILE: design/scpf_front.sv
// Front end of the framer: classifies each input transaction into a command.
// Tracks frame position (in frame, payload bytes left). Depends on scpf_pkg.
module scpf_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  scpf_pkg::in_item_t item_i,
  output scpf_pkg::cmd_t   cmd_o
);
  import scpf_pkg::*;

  logic       in_frame_q, in_frame_d;
  logic [9:0] remaining_q, remaining_d;

  always_comb begin
    cmd_o       = '0;
    cmd_o.dest  = item_i.dest_address;
    cmd_o.msg   = item_i.message_number;
    cmd_o.ptype = item_i.packet_type;
    cmd_o.len   = item_i.payload_length;
    cmd_o.pbyte = item_i.payload_byte;
    in_frame_d  = in_frame_q;
    remaining_d = remaining_q;
    if (in_frame_q) begin
      cmd_o.kind = CMD_PAY;
      cmd_o.last = (remaining_q == 10'd1);
      if (accept_i) begin
        remaining_d = remaining_q - 10'd1;
        if (remaining_q == 10'd1) begin
          in_frame_d = 1'b0;
        end
      end
    end else if (item_i.payload_length > MAX_PAYLOAD) begin
      cmd_o.kind = CMD_ERR;
    end else begin
      cmd_o.kind = CMD_HDR;
      cmd_o.last = (item_i.payload_length <= 10'd1);
      // header item carries the first payload byte; stay in frame if more follow
      if (accept_i && item_i.payload_length > 10'd1) begin
        in_frame_d  = 1'b1;
        remaining_d = item_i.payload_length - 10'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q  <= 1'b0;
      remaining_q <= '0;
    end else begin
      in_frame_q  <= in_frame_d;
      remaining_q <= remaining_d;
    end
  end

endmodule

FILE: design/scpf_queue.sv
// Short command FIFO between the front and back ends of the framer.
// Register-based, first-word fall-through. Depends on scpf_pkg.
module scpf_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  scpf_pkg::cmd_t       push_cmd_i,
  input  logic                 pop_i,
  output scpf_pkg::cmd_t       head_o,
  output scpf_pkg::q_status_t  status_o
);
  import scpf_pkg::*;

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_push, do_pop;

  assign status_o.head_valid = (count_q != '0);
  assign status_o.full       = (count_q == QCNT_W'(QDEPTH));
  assign head_o              = mem_q[rd_ptr_q];
  assign do_push             = push_i && !status_o.full;
  assign do_pop              = pop_i && status_o.head_valid;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + QCNT_W'(1);
        2'b01:   count_q <= count_q - QCNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

FILE: design/scpf_back.sv
// Back end of the framer: expands commands into frame bytes, keeps the
// running checksum and drives the registered output. Depends on scpf_pkg.
module scpf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  scpf_pkg::cmd_t      head_i,
  input  scpf_pkg::q_status_t q_status_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output scpf_pkg::out_item_t out_o
);
  import scpf_pkg::*;

  cmd_t       cur_q, cur_d;
  logic       busy_q, busy_d;
  logic [3:0] step_q, step_d;
  logic [7:0] sum_q, sum_d;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_q, out_d;

  logic        adv;
  logic        done;
  logic [3:0]  step_nxt;
  logic [7:0]  cur_byte;
  logic [10:0] total;

  assign adv   = !out_valid_q || !out_stall_i;
  assign total = {1'b0, cur_q.len} + FRAME_OVERHEAD;

  // Byte for the current step
  always_comb begin
    case (step_q)
      4'd0:     cur_byte = SYNC_BYTE_0;
      4'd1:     cur_byte = SYNC_BYTE_1;
      4'd2:     cur_byte = total[7:0];
      4'd3:     cur_byte = {5'd0, total[10:8]};
      4'd4:     cur_byte = cur_q.dest;
      4'd6:     cur_byte = cur_q.msg;
      4'd8:     cur_byte = cur_q.ptype[7:0];
      4'd9:     cur_byte = cur_q.ptype[15:8];
      STEP_PAY: cur_byte = cur_q.pbyte;
      STEP_CHK: cur_byte = sum_q;
      default:  cur_byte = 8'd0;
    endcase
  end

  // Next step and end-of-command detection
  always_comb begin
    step_nxt = step_q + 4'd1;
    done     = 1'b0;
    if (step_q == STEP_HDR_LAST) begin
      step_nxt = (cur_q.len != 10'd0) ? STEP_PAY : STEP_CHK;
    end else if (step_q == STEP_PAY) begin
      step_nxt = STEP_CHK;
      done     = !cur_q.last;
    end else if (step_q == STEP_CHK || step_q == STEP_ERR) begin
      done = 1'b1;
    end
  end

  always_comb begin
    cur_d       = cur_q;
    busy_d      = busy_q;
    step_d      = step_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    pop_o       = 1'b0;

    if (adv) begin
      out_valid_d = 1'b0;
    end
    if (busy_q && adv) begin
      out_valid_d         = 1'b1;
      out_d.frame_byte    = cur_byte;
      out_d.last_of_frame = (step_q == STEP_CHK);
      out_d.length_error  = (step_q == STEP_ERR);
      if (step_q == STEP_CHK) begin
        sum_d = 8'd0;
      end else if (step_q == 4'd0) begin
        sum_d = cur_byte;
      end else if (step_q != STEP_ERR) begin
        sum_d = sum_q + cur_byte;
      end
      step_d = step_nxt;
      if (done) begin
        busy_d = 1'b0;
      end
    end

    // Load the next command when idle or finishing the current one
    if ((!busy_q || (adv && done)) && q_status_i.head_valid) begin
      pop_o  = 1'b1;
      cur_d  = head_i;
      busy_d = 1'b1;
      case (head_i.kind)
        CMD_HDR: step_d = 4'd0;
        CMD_PAY: step_d = STEP_PAY;
        default: step_d = STEP_ERR;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

FILE: design/sum_checksum_packet_framer_unit.sv
// Top level of the sum-checksum packet framer.
// Instantiates scpf_front, scpf_queue and scpf_back; depends on scpf_pkg.
//
// Turns input transactions into a byte stream of link frames. The first
// transaction of a frame carries destination, message number, packet type
// and payload length (plus the first payload byte when the length is
// nonzero); each later transaction carries one payload byte. Output per
// frame: 0x44 0x4B, total length (payload + 11, little endian), destination,
// 0x00, message number, 0x00, packet type (little endian), the payload, and
// the 8-bit additive checksum of all earlier bytes with last_of_frame set.
// A payload length above MAX_PAYLOAD gives one output transaction with
// length_error set and frame_byte zero; no frame follows. Rate: the back end
// emits one output byte per cycle while out_stall_i holds no output, so a payload
// transaction yields one byte (two when it also closes the frame with the
// checksum), a header transaction yields 11 or 12 bytes and a rejected length
// yields one; the four-entry command queue lets the input side run ahead of a
// header burst and backpressure covers the rest. With the back end idle, an
// accepted item is queued, loaded into cur_q and its byte registered in out_q.
module sum_checksum_packet_framer_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  scpf_pkg::in_item_t  in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output scpf_pkg::out_item_t out_o
);
  import scpf_pkg::*;

  logic      in_accept;
  cmd_t      front_cmd;
  cmd_t      q_head;
  q_status_t q_status;
  logic      q_pop;

  assign in_stall_o = q_status.full;
  assign in_accept  = in_valid_i && !in_stall_o;

  scpf_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .item_i   (in_i),
    .cmd_o    (front_cmd)
  );

  scpf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_accept),
    .push_cmd_i (front_cmd),
    .pop_i      (q_pop),
    .head_o     (q_head),
    .status_o   (q_status)
  );

  scpf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .q_status_i  (q_status),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

`ifndef SYNTHESIS
  // An error result never carries frame data
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.length_error) |-> (out_o.frame_byte == 8'd0 && !out_o.last_of_frame))
    else $error("length error result carries frame data");

  // A full queue always has a command at its head
  a_full_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.full |-> q_status.head_valid)
    else $error("queue full without head entry");

  // The back end only pops when the queue has an entry
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_status.head_valid)
    else $error("pop from empty command queue");
`endif

endmodule
